>>> design/sst_pkg.sv
// shared types and constants for the sorted score table
package sst_pkg;
    localparam int ACT_BITS   = 2;
    localparam int SCORE_BITS = 7;
    localparam int STAT_BITS  = 3;
    localparam int FOUND_BITS = 16;
    localparam int IN_ID_BITS = 16;
    localparam logic [SCORE_BITS-1:0] MAX_SCORE = 7'd100;

    typedef enum logic [ACT_BITS-1:0] {
        ACT_ADD    = 2'd0,
        ACT_UPDATE = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_GET    = 2'd3
    } t_action;

    typedef enum logic [STAT_BITS-1:0] {
        ST_OK        = 3'd0,
        ST_BAD_SCORE = 3'd1,
        ST_EXISTS    = 3'd2,
        ST_NO_ID     = 3'd3,
        ST_NO_SCORE  = 3'd4,
        ST_FULL      = 3'd5
    } t_status;

    typedef struct packed {
        t_action                act;
        logic                   bad_score;
        logic [IN_ID_BITS-1:0]  id;
        logic [SCORE_BITS-1:0]  score;
    } t_cmd;
endpackage

>>> design/sst_front.sv
// front end: takes an item, masks the identifier, flags an out-of-range score
module sst_front #(
    parameter int ID_BITS = 16
) (
    input  logic                        i_start,
    input  logic [sst_pkg::ACT_BITS-1:0]   i_action,
    input  logic [sst_pkg::IN_ID_BITS-1:0] i_student_id,
    input  logic [sst_pkg::SCORE_BITS-1:0] i_score,
    input  logic                        i_q_full,
    output logic                        o_busy,
    output logic                        o_push,
    output sst_pkg::t_cmd               o_cmd
);
    localparam int KB = (ID_BITS < sst_pkg::IN_ID_BITS) ? ID_BITS : sst_pkg::IN_ID_BITS;
    logic [sst_pkg::IN_ID_BITS-1:0] w_mask;
    assign w_mask = {sst_pkg::IN_ID_BITS{1'b1}} >> (sst_pkg::IN_ID_BITS - KB);

    assign o_busy = i_q_full;
    assign o_push = i_start && !i_q_full;
    always_comb begin
        o_cmd.act       = sst_pkg::t_action'(i_action);
        o_cmd.bad_score = i_score > sst_pkg::MAX_SCORE;
        o_cmd.id        = i_student_id & w_mask;
        o_cmd.score     = i_score;
    end
endmodule

>>> design/sst_queue.sv
// two-entry command queue between front and back
module sst_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sst_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output sst_pkg::t_cmd o_cmd
);
    sst_pkg::t_cmd r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_cmd   = r_mem[r_rp];
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_cmd;
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end
endmodule

>>> design/sst_back.sv
// back end: cell chain of ordered entries, compare in parallel, shift to insert or delete
module sst_back #(
    parameter int CAPACITY = 64,
    parameter int ID_BITS  = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  sst_pkg::t_cmd i_cmd,
    output logic          o_pop,
    output logic          o_done,
    output logic [sst_pkg::STAT_BITS-1:0]  o_status,
    output logic [sst_pkg::FOUND_BITS-1:0] o_found_id
);
    localparam int CB = $clog2(CAPACITY + 1);
    localparam int KB = (ID_BITS < sst_pkg::IN_ID_BITS) ? ID_BITS : sst_pkg::IN_ID_BITS;
    localparam int SB = sst_pkg::SCORE_BITS;

    typedef enum logic [0:0] {S_LOOK, S_MOVE} t_state;
    t_state r_state;

    logic [SB-1:0] r_sc [CAPACITY];
    logic [KB-1:0] r_id [CAPACITY];
    logic [CB-1:0] r_count;

    // per-cell flags computed in the look step
    logic [CAPACITY-1:0] w_vld, w_hit, w_less, r_hit, r_less;
    logic [KB-1:0] w_key;
    assign w_key = i_cmd.id[KB-1:0];
    logic [SB-1:0] w_qsc;
    assign w_qsc = i_cmd.score;

    always_comb begin
        for (int k = 0; k < CAPACITY; k++) begin
            w_vld[k]  = CB'(k) < r_count;
            w_hit[k]  = w_vld[k] && r_id[k] == w_key;
            w_less[k] = w_vld[k] && (r_sc[k] < w_qsc ||
                        (r_sc[k] == w_qsc && r_id[k] < w_key));
        end
    end

    // get: first cell with matching score via priority pick
    logic          w_gfound;
    logic [KB-1:0] w_gid;
    always_comb begin
        w_gfound = 1'b0;
        w_gid    = '0;
        for (int k = CAPACITY-1; k >= 0; k--) begin
            if (w_vld[k] && r_sc[k] == w_qsc) begin
                w_gfound = 1'b1;
                w_gid    = r_id[k];
            end
        end
    end

    sst_pkg::t_cmd r_cmd;
    assign o_pop = (r_state == S_MOVE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOOK;
            r_count <= '0;
            o_done  <= 1'b0;
            o_status <= sst_pkg::ST_OK;
            o_found_id <= '0;
        end else begin
            o_done <= 1'b0;
            case (r_state)
                S_LOOK: begin
                    if (i_valid) begin
                        r_cmd   <= i_cmd;
                        r_hit   <= w_hit;
                        r_less  <= w_less;
                        r_state <= S_MOVE;
                        o_found_id <= '0;
                        o_status <= sst_pkg::ST_OK;
                        case (i_cmd.act)
                            sst_pkg::ACT_ADD: begin
                                if (i_cmd.bad_score) o_status <= sst_pkg::ST_BAD_SCORE;
                                else if (|w_hit) o_status <= sst_pkg::ST_EXISTS;
                                else if (r_count >= CB'(CAPACITY)) o_status <= sst_pkg::ST_FULL;
                            end
                            sst_pkg::ACT_UPDATE: begin
                                if (i_cmd.bad_score) o_status <= sst_pkg::ST_BAD_SCORE;
                                else if (!(|w_hit)) o_status <= sst_pkg::ST_NO_ID;
                            end
                            sst_pkg::ACT_REMOVE: begin
                                if (!(|w_hit)) o_status <= sst_pkg::ST_NO_ID;
                            end
                            default: begin
                                if (w_gfound) o_found_id <= sst_pkg::FOUND_BITS'(w_gid);
                                else o_status <= sst_pkg::ST_NO_SCORE;
                            end
                        endcase
                    end
                end
                default: begin
                    o_done  <= 1'b1;
                    r_state <= S_LOOK;
                    if (o_status == sst_pkg::ST_OK) begin
                        case (r_cmd.act)
                            sst_pkg::ACT_ADD: r_count <= r_count + 1'b1;
                            sst_pkg::ACT_REMOVE: r_count <= r_count - 1'b1;
                            default: ;
                        endcase
                    end
                end
            endcase
        end
    end

    // cell shifting; position flags: del = hit found below or at k, ltb = entry less than new key
    logic [CAPACITY-1:0] w_delb; // some hit at index <= k
    logic [CAPACITY-1:0] w_ltb;  // entry k stays left of new key (after delete view)
    logic w_doins, w_dodel;
    always_comb begin
        w_dodel = (o_status == sst_pkg::ST_OK) &&
                  (r_cmd.act == sst_pkg::ACT_REMOVE || r_cmd.act == sst_pkg::ACT_UPDATE);
        w_doins = (o_status == sst_pkg::ST_OK) &&
                  (r_cmd.act == sst_pkg::ACT_ADD || r_cmd.act == sst_pkg::ACT_UPDATE);
        w_delb[0] = r_hit[0];
        for (int k = 1; k < CAPACITY; k++) w_delb[k] = w_delb[k-1] | r_hit[k];
    end

    // compacted view after delete: c[k] = delb[k] ? old[k+1] : old[k]
    logic [SB-1:0] c_sc [CAPACITY];
    logic [KB-1:0] c_id [CAPACITY];
    logic [CAPACITY-1:0] c_less;
    always_comb begin
        for (int k = 0; k < CAPACITY; k++) begin
            if (w_dodel && w_delb[k] && k < CAPACITY-1) begin
                c_sc[k] = r_sc[(k < CAPACITY-1) ? k+1 : k];
                c_id[k] = r_id[(k < CAPACITY-1) ? k+1 : k];
                c_less[k] = r_less[(k < CAPACITY-1) ? k+1 : k];
            end else begin
                c_sc[k] = r_sc[k];
                c_id[k] = r_id[k];
                c_less[k] = r_less[k] && !(w_dodel && w_delb[k]);
            end
        end
        for (int k = 0; k < CAPACITY; k++) w_ltb[k] = c_less[k];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_MOVE) begin
            for (int k = 0; k < CAPACITY; k++) begin
                if (!w_doins || w_ltb[k]) begin
                    r_sc[k] <= c_sc[k];
                    r_id[k] <= c_id[k];
                end else if (k == 0 || w_ltb[(k > 0) ? k-1 : 0]) begin
                    r_sc[k] <= r_cmd.score;
                    r_id[k] <= r_cmd.id[KB-1:0];
                end else begin
                    r_sc[k] <= c_sc[(k > 0) ? k-1 : 0];
                    r_id[k] <= c_id[(k > 0) ? k-1 : 0];
                end
            end
        end
    end
endmodule

>>> design/sorted_score_table.sv
// sorted score table top level
// path: a taken start is written into the queue, then passes the look and move steps of the cell chain
// o_done is registered in the move step; the chain takes a new item only after moving the last one
// a two-entry queue lets start be taken while the chain works; busy rises when it fills
// synchronous active-low reset empties the table and the queue
// o_done marks each result for one cycle; the receiver cannot stall
module sorted_score_table #(
    parameter int CAPACITY = 64,
    parameter int ID_BITS  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_action,
    input  logic [15:0] i_student_id,
    input  logic [6:0]  i_score,
    output logic        o_done,
    output logic [2:0]  o_status,
    output logic [15:0] o_found_id
);
    logic w_push, w_full, w_valid, w_pop;
    sst_pkg::t_cmd w_in, w_q;

    sst_front #(.ID_BITS(ID_BITS)) u_front (
        .i_start(start), .i_action, .i_student_id, .i_score,
        .i_q_full(w_full), .o_busy(busy), .o_push(w_push), .o_cmd(w_in));

    sst_queue u_queue (
        .i_clk, .i_rst_n, .i_push(w_push), .i_cmd(w_in), .i_pop(w_pop),
        .o_full(w_full), .o_valid(w_valid), .o_cmd(w_q));

    sst_back #(.CAPACITY(CAPACITY), .ID_BITS(ID_BITS)) u_back (
        .i_clk, .i_rst_n, .i_valid(w_valid), .i_cmd(w_q), .o_pop(w_pop),
        .o_done, .o_status, .o_found_id);
endmodule

>>> design/sst_checker.sv
// port-level checks for the sorted score table
module sst_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_done,
    input logic [2:0]  o_status,
    input logic [15:0] o_found_id
);
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_status <= sst_pkg::ST_FULL) else $error("bad status");
    a_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != sst_pkg::ST_OK) |-> o_found_id == 16'd0)
        else $error("found id set");
    a_done_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("back to back results");
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !busy && !o_done) else $error("not idle after reset");
endmodule

bind sorted_score_table sst_checker u_sst_checker (
    .i_clk, .i_rst_n, .start, .busy, .o_done, .o_status, .o_found_id);
